// File: hw/rtl/smallest_prime_factor_sieve_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the smallest prime factor unit
// Shared concurrent-check forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SMALLEST_PRIME_FACTOR_SIEVE_MACROS_SVH
`define SMALLEST_PRIME_FACTOR_SIEVE_MACROS_SVH

// same-cycle implication
`define SPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Widths, result kinds and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int NumW   = 15;
  localparam int DivW   = 8;   // trial divisor, never above 183
  localparam int StepW  = 3;   // eight two-bit division steps
  localparam int DvdW   = 16;  // number padded to whole bit pairs

  // result kinds selected by the controller
  localparam logic [1:0] RES_SMALL = 2'd0;  // number is 0 or 1
  localparam logic [1:0] RES_SELF  = 2'd1;  // no divisor up to sqrt: prime
  localparam logic [1:0] RES_DIV   = 2'd2;  // trial divisor divides

  typedef struct packed {
    logic       load;      // capture request number, divisor = 2
    logic       start;     // clear remainder, load dividend
    logic       step;      // two restoring division steps
    logic       d_next;    // advance trial divisor
    logic       set_res;   // latch result of res_kind
    logic [1:0] res_kind;
    logic       publish;   // move result into output register
  } cmd_t;

  typedef struct packed {
    logic n_small;   // number below 2
    logic sq_gt;     // divisor squared exceeds number
    logic rem_zero;  // remainder is zero
    logic div_last;  // final division step this cycle
  } sts_t;

endpackage

// File: hw/rtl/sps_ctrl.sv
// ----------------------------------------------------------------------------
// sps_ctrl
// Sequencer for trial division: square test, division, result hand-off.
// ----------------------------------------------------------------------------
module sps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  sps_pkg::sts_t sts,
  output sps_pkg::cmd_t cmd
);
  import sps_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_TEST  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_pub;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign can_pub    = !out_valid_r || out_tready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.n_small) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_SMALL;
          state_nxt    = ST_FIN;
        end else if (sts.sq_gt) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_SELF;
          state_nxt    = ST_FIN;
        end else begin
          cmd.start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (sts.rem_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_DIV;
          state_nxt    = ST_FIN;
        end else begin
          cmd.d_next = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_FIN: begin
        if (can_pub) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/sps_dpath.sv
// ----------------------------------------------------------------------------
// sps_dpath
// Number, trial divisor, radix-4 restoring remainder unit and result regs.
// ----------------------------------------------------------------------------
module sps_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [sps_pkg::NumW-1:0]  number,
  input  sps_pkg::cmd_t             cmd,
  output sps_pkg::sts_t             sts,
  output logic [sps_pkg::NumW-1:0]  out_factor,
  output logic                      out_prime
);
  import sps_pkg::*;

  logic [NumW-1:0]  num_r;
  logic [DivW-1:0]  d_r;
  logic [DivW-1:0]  rem_r, rem_nxt;
  logic [DvdW-1:0]  dvd_r;
  logic [StepW-1:0] cnt_r;
  logic [NumW-1:0]  res_factor_r, out_factor_r;
  logic             res_prime_r, out_prime_r;
  logic [2*DivW-1:0] d_sq;
  logic [DivW:0]    r1, r2;
  logic [DivW-1:0]  r1c;

  // square test
  assign d_sq = d_r * d_r;

  assign sts.n_small  = (num_r < NumW'(2));
  assign sts.sq_gt    = (d_sq > {1'b0, num_r});
  assign sts.rem_zero = (rem_r == '0);
  assign sts.div_last = (cnt_r == '1);

  // two restoring steps per cycle
  always_comb begin
    r1 = {rem_r, dvd_r[DvdW-1]};
    if (r1 >= {1'b0, d_r}) r1 = r1 - {1'b0, d_r};
    r1c = r1[DivW-1:0];
    r2 = {r1c, dvd_r[DvdW-2]};
    if (r2 >= {1'b0, d_r}) r2 = r2 - {1'b0, d_r};
    rem_nxt = r2[DivW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r <= number;
      d_r   <= DivW'(2);
    end else if (cmd.d_next) begin
      d_r <= (d_r == DivW'(2)) ? DivW'(3) : d_r + DivW'(2);
    end
    if (cmd.start) begin
      rem_r <= '0;
      dvd_r <= {1'b0, num_r};
    end else if (cmd.step) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DvdW-3:0], 2'b00};
    end
    // result selection
    if (cmd.set_res) begin
      case (cmd.res_kind)
        RES_SMALL: begin
          res_factor_r <= (num_r == '0) ? NumW'(2) : '0;
          res_prime_r  <= 1'b0;
        end
        RES_SELF: begin
          res_factor_r <= num_r;
          res_prime_r  <= 1'b1;
        end
        default: begin
          res_factor_r <= NumW'(d_r);
          res_prime_r  <= 1'b0;
        end
      endcase
    end
    if (cmd.publish) begin
      out_factor_r <= res_factor_r;
      out_prime_r  <= res_prime_r;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.start) cnt_r <= '0;
    else if (cmd.step) cnt_r <= cnt_r + StepW'(1);
  end

  assign out_factor = out_factor_r;
  assign out_prime  = out_prime_r;

endmodule

// File: hw/rtl/smallest_prime_factor_sieve.sv
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve
// Smallest prime factor and primality of a 15-bit number.
// ----------------------------------------------------------------------------
// One request at a time. The number is trial-divided by 2 and then by odd
// divisors until one divides it or the divisor's square exceeds it; the first
// divisor that divides is the smallest prime factor, and if none does the
// number itself is prime. Each trial is a square test, a pass of the
// two-bit-per-cycle remainder unit over the number and a remainder test.
// Numbers 0 and 1 skip the trials; the longest request is 32761 (181
// squared). A finished result waits while the previous one is still held
// and out_tready is low. Number 1 gives factor 0, number 0 gives factor 2;
// neither is flagged prime.
module smallest_prime_factor_sieve (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [14:0] number
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] smallest_factor
  output logic        out_tuser   // [0] is_prime
);
  import sps_pkg::*;

  `include "smallest_prime_factor_sieve_macros.svh"

  cmd_t            cmd;
  sts_t            sts;
  logic [NumW-1:0] factor;
  logic            prime;

  sps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sps_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .number     (in_tdata[NumW-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_factor (factor),
    .out_prime  (prime)
  );

  assign out_tdata = {1'b0, factor};
  assign out_tuser = prime;

  // checks
  `SPS_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready, "ready after request")
  `SPS_ASSERT_NOW(a_prime_ge2, out_tvalid && out_tuser, out_tdata[14:0] >= 15'd2, "prime below 2")
  `SPS_ASSERT_NOW(a_even_prime, out_tvalid && out_tuser && !out_tdata[0], out_tdata[14:0] == 15'd2, "even prime not 2")
  `SPS_ASSERT_NOW(a_one_cmd, cmd.step, !cmd.start && !cmd.set_res && !cmd.publish, "command overlap")

endmodule

// File: bench/tb_smallest_prime_factor_sieve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smallest_prime_factor_sieve
// Self-checking bench for the smallest prime factor unit.
// ----------------------------------------------------------------------------
// A directed table (zero, one, extremes, prime squares, the largest prime)
// is followed by random numbers. Rows with no expected value and all random
// numbers are predicted by trial division. Results are compared in order.
// Both sides idle at random. The receiver holds off once for a long stretch.
// The sender lets the unit drain after the table and again halfway through.
module tb_smallest_prime_factor_sieve;
  import sps_pkg::*;

  localparam int NumRandom = 560;

  typedef struct {
    logic [NumW-1:0] factor;
    logic            prime;
  } spf_result_t;

  typedef struct {
    logic [NumW-1:0] number;
    bit              typed;   // expected value given in the row
    logic [NumW-1:0] factor;
    logic            prime;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;

  spf_result_t pending_results[$];
  spf_result_t next_request_result;
  int          error_count = 0;
  int          results_seen = 0;
  bit          stimulus_done = 1'b0;

  smallest_prime_factor_sieve dut (.*);

  always #4 clk = ~clk;

  // smallest prime factor by trial division; 0 -> 2, 1 -> 0
  function automatic spf_result_t predict_spf(logic [NumW-1:0] n);
    spf_result_t r;
    int d;
    r.factor = n;
    if (n == 0) r.factor = NumW'(2);
    else if (n == 1) r.factor = '0;
    else begin
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) begin
          r.factor = NumW'(d);
          break;
        end
      end
    end
    r.prime = (n >= 2) && (r.factor == n);
    return r;
  endfunction

  // capture expectations at request acceptance, check results
  always @(posedge clk) begin
    spf_result_t e;
    if (rst_n && in_tvalid && in_tready) pending_results.push_back(next_request_result);
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: factor %0d", out_tdata[NumW-1:0]);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[NumW-1:0] !== e.factor) begin
          $error("smallest_factor: expected %0d, actual %0d", e.factor,
                 out_tdata[NumW-1:0]);
          error_count++;
        end
        if (out_tuser !== e.prime) begin
          $error("is_prime: expected %0d, actual %0d", e.prime, out_tuser);
          error_count++;
        end
      end
    end
  end

  // send one request after a random gap
  task automatic send_number(logic [NumW-1:0] n, spf_result_t exp_res);
    int gap;
    gap = $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, n};
    next_request_result <= exp_res;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // sender
  initial begin
    stim_row_t table_rows[$];
    spf_result_t r;
    logic [NumW-1:0] n;
    int a;
    int kind;
    table_rows = '{
      '{15'd0,     1, 15'd2,     1'b0},
      '{15'd1,     1, 15'd0,     1'b0},
      '{15'd2,     1, 15'd2,     1'b1},
      '{15'd3,     1, 15'd3,     1'b1},
      '{15'd4,     1, 15'd2,     1'b0},
      '{15'd32767, 1, 15'd7,     1'b0},
      '{15'd32749, 1, 15'd32749, 1'b1},
      '{15'd32766, 1, 15'd2,     1'b0},
      '{15'd16384, 1, 15'd2,     1'b0},
      '{15'd25,    0, 15'd0,     1'b0},   // prime squares
      '{15'd49,    0, 15'd0,     1'b0},
      '{15'd289,   0, 15'd0,     1'b0},
      '{15'd32761, 0, 15'd0,     1'b0},   // 181 squared
      '{15'd32399, 0, 15'd0,     1'b0},
      '{15'd17,    0, 15'd0,     1'b0},
      '{15'd21845, 0, 15'd0,     1'b0},
      '{15'd10922, 0, 15'd0,     1'b0},
      '{15'd1021,  0, 15'd0,     1'b0},
      '{15'd32719, 0, 15'd0,     1'b0},
      '{15'd5,     0, 15'd0,     1'b0}
    };
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (table_rows[i]) begin
      if (table_rows[i].typed) begin
        r.factor = table_rows[i].factor;
        r.prime = table_rows[i].prime;
      end else r = predict_spf(table_rows[i].number);
      send_number(table_rows[i].number, r);
    end
    wait_drained();
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) wait_drained();
      kind = $urandom_range(0, 9);
      if (kind < 6) n = NumW'($urandom_range(0, 32767));
      else if (kind < 8) n = NumW'($urandom_range(0, 300));
      else begin
        a = $urandom_range(2, 181);
        n = NumW'(a * a);
      end
      send_number(n, predict_spf(n));
    end
    in_tvalid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // receiver, with one long hold-off
  initial begin
    int stall;
    forever begin
      stall = (results_seen == 40) ? 3000 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // end of run
  initial begin
    wait (stimulus_done);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (1000) @(negedge clk);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
